### sv/assert_macros.svh
// assertion macros for the requantizer rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define FPR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge
`define FPR_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/fpr_pkg.sv
`timescale 1ns / 1ps
// package for the fixed point requantizer: config struct, mode codes,
// wide arithmetic helpers; no dependencies
package fpr_pkg;

    localparam int WIDE_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int CNT_W      = 48;
    localparam int SH_W       = 6;
    localparam int SH_CAP     = 62;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_BITS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREC_BITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRUNE_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRUNE_LSB    = 3'd4;

    localparam logic [2:0] MODE_PASS       = 3'd0;
    localparam logic [2:0] MODE_CLAMP      = 3'd1;
    localparam logic [2:0] MODE_TRUNC      = 3'd2;
    localparam logic [2:0] MODE_ROUND_CLMP = 3'd3;
    localparam logic [2:0] MODE_CLMP_TRUNC = 3'd4;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [SH_W-1:0]          t_shift;

    typedef struct packed {
        logic [2:0]        limit_mode;
        logic [3:0]        mag_bits;
        logic signed [5:0] prec_bits;
        logic              prune_enable;
        logic signed [4:0] prune_lsb;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        limit_mode:   MODE_PASS,
        mag_bits:     4'd14,
        prec_bits:    6'sd16,
        prune_enable: 1'b0,
        prune_lsb:    5'sd0
    };

    function automatic logic [WIDE_W-1:0] f_magn(input t_wide x);
        return x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
    endfunction

    function automatic t_wide f_trunc(input t_wide x, input t_shift sh);
        logic [WIDE_W-1:0] m;
        m = f_magn(x) & ({WIDE_W{1'b1}} << sh);
        return x[WIDE_W-1] ? -t_wide'(m) : t_wide'(m);
    endfunction

    function automatic t_wide f_round(input t_wide x, input t_shift sh);
        logic [WIDE_W-1:0] m;
        logic [WIDE_W-1:0] half;
        half = (sh != '0) ? (WIDE_W'(1) << SH_W'(sh - SH_W'(1))) : '0;
        m    = (f_magn(x) + half) & ({WIDE_W{1'b1}} << sh);
        return x[WIDE_W-1] ? -t_wide'(m) : t_wide'(m);
    endfunction

    function automatic t_wide f_clamp(input t_wide x, input t_wide b);
        t_wide y;
        y = x;
        if (y > b) y = b;
        if (y < -b) y = -b;
        return y;
    endfunction

endpackage

### sv/fpr_limit.sv
`timescale 1ns / 1ps
// requantizer limit stage: pass, clamp, truncate or round by mode into a wide register
// depends on fpr_pkg
module fpr_limit #(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fpr_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output fpr_pkg::t_wide                 o_value
);

    logic           r_valid;
    fpr_pkg::t_wide r_value;
    fpr_pkg::t_wide n_value;

    logic signed [7:0] s_full;
    fpr_pkg::t_shift   sh;
    fpr_pkg::t_wide    x;
    fpr_pkg::t_wide    bound;
    fpr_pkg::t_wide    hi;
    fpr_pkg::t_wide    y;

    always_comb begin
        s_full = 8'(FRAC_BITS) - {{2{i_cfg.prec_bits[5]}}, i_cfg.prec_bits};
        if (s_full < 0) begin
            sh = '0;
        end else if (s_full > 8'(fpr_pkg::SH_CAP)) begin
            sh = fpr_pkg::SH_W'(fpr_pkg::SH_CAP);
        end else begin
            sh = s_full[fpr_pkg::SH_W-1:0];
        end
        x     = fpr_pkg::t_wide'(i_sample);
        bound = fpr_pkg::t_wide'(fpr_pkg::WIDE_W'(1) << (7'(i_cfg.mag_bits) + 7'(FRAC_BITS)));
        hi    = bound - fpr_pkg::t_wide'(fpr_pkg::WIDE_W'(1) << sh);
        y     = x;
        case (i_cfg.limit_mode)
            fpr_pkg::MODE_CLAMP: begin
                y = fpr_pkg::f_clamp(x, bound);
            end
            fpr_pkg::MODE_TRUNC: begin
                y = fpr_pkg::f_trunc(x, sh);
            end
            fpr_pkg::MODE_ROUND_CLMP: begin
                y = i_cfg.prec_bits[5] ? fpr_pkg::f_trunc(x, sh) : fpr_pkg::f_round(x, sh);
                if (y > hi) y = hi;
                if (y < -bound) y = -bound;
            end
            fpr_pkg::MODE_CLMP_TRUNC: begin
                y = fpr_pkg::f_trunc(fpr_pkg::f_clamp(x, bound), sh);
            end
            default: begin
                y = x;
            end
        endcase
        n_value = y;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_value <= n_value;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

### sv/fpr_post.sv
`timescale 1ns / 1ps
// requantizer output stage: sample range saturation, deadzone, counters, result register
// depends on fpr_pkg and assert_macros.svh
`include "assert_macros.svh"
module fpr_post #(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fpr_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  fpr_pkg::t_wide                 i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_quantized,
    output logic                           o_is_zero,
    output logic [fpr_pkg::CNT_W-1:0]      o_zero_total,
    output logic [fpr_pkg::CNT_W-1:0]      o_sample_total
);

    localparam fpr_pkg::t_wide SMAX =
        fpr_pkg::t_wide'((fpr_pkg::WIDE_W'(1) << (SAMPLE_WIDTH - 1)) - fpr_pkg::WIDE_W'(1));
    localparam fpr_pkg::t_wide SMIN = -SMAX - fpr_pkg::t_wide'(1);

    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_quantized;
    logic                           r_is_zero;
    logic [fpr_pkg::CNT_W-1:0]      r_zero_cnt;
    logic [fpr_pkg::CNT_W-1:0]      r_sample_cnt;

    logic signed [SAMPLE_WIDTH-1:0] n_quantized;
    logic                           n_is_zero;
    logic [fpr_pkg::CNT_W-1:0]      n_zero_cnt;
    logic [fpr_pkg::CNT_W-1:0]      n_sample_cnt;

    fpr_pkg::t_wide    y;
    logic signed [6:0] e;
    logic              take;

    always_comb begin
        y = i_value;
        if (y > SMAX) y = SMAX;
        if (y < SMIN) y = SMIN;
        e = 7'(FRAC_BITS) + {{2{i_cfg.prune_lsb[4]}}, i_cfg.prune_lsb};
        if (i_cfg.prune_enable && !e[6]) begin
            if (fpr_pkg::f_magn(y) < (fpr_pkg::WIDE_W'(1) << e[5:0])) y = '0;
        end
        n_quantized  = y[SAMPLE_WIDTH-1:0];
        n_is_zero    = (y == '0);
        n_sample_cnt = (r_sample_cnt != '1) ? r_sample_cnt + 1'b1 : r_sample_cnt;
        n_zero_cnt   = (n_is_zero && r_zero_cnt != '1) ? r_zero_cnt + 1'b1 : r_zero_cnt;
    end

    assign o_ready = !r_valid || i_ready;
    assign take    = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_zero_cnt   <= '0;
            r_sample_cnt <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_zero_cnt   <= n_zero_cnt;
                r_sample_cnt <= n_sample_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_quantized <= n_quantized;
            r_is_zero   <= n_is_zero;
        end
    end

    assign o_valid        = r_valid;
    assign o_quantized    = r_quantized;
    assign o_is_zero      = r_is_zero;
    assign o_zero_total   = r_zero_cnt;
    assign o_sample_total = r_sample_cnt;

    `FPR_ASSERT_RST(a_zero_le_total, i_clk, i_rst_n, r_zero_cnt <= r_sample_cnt, "zero count above sample count")
    `FPR_ASSERT_RST(a_cnt_monotonic, i_clk, i_rst_n, $past(i_rst_n) |-> r_sample_cnt >= $past(r_sample_cnt), "sample count went down")
    `FPR_ASSERT_RST(a_zero_flag, i_clk, i_rst_n, r_valid |-> (r_is_zero == (r_quantized == '0)), "zero flag disagrees with result")

endmodule

### sv/fixed_point_requantizer.sv
`timescale 1ns / 1ps
// an accepted request passes the input register, the limit stage and the output stage
// in that order to the master side; one request per cycle while no stage stalls;
// each stage holds one request and stalls only when the stage ahead is full
// reset (synchronous, active low) empties the pipeline, clears both counters
// and returns the config registers to their reset values
// depends on fpr_pkg, fpr_limit, fpr_post
module fixed_point_requantizer #(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fpr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fpr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // quantized, zero_total, sample_total
    output logic [((SAMPLE_WIDTH+96+7)/8)*8-1:0]  m_axis_tdata,
    // is_zero
    output logic                                  m_axis_tuser
);

    localparam int OUT_W = ((SAMPLE_WIDTH + 96 + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - SAMPLE_WIDTH - 2 * fpr_pkg::CNT_W;

    fpr_pkg::t_cfg r_cfg;

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;

    logic                           lim_ready;
    logic                           lim_valid;
    fpr_pkg::t_wide                 lim_value;
    logic                           post_ready;

    logic signed [SAMPLE_WIDTH-1:0] quantized;
    logic [fpr_pkg::CNT_W-1:0]      zero_total;
    logic [fpr_pkg::CNT_W-1:0]      sample_total;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fpr_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpr_pkg::REG_LIMIT_MODE:   r_cfg.limit_mode   <= i_cfg_data[2:0];
                fpr_pkg::REG_MAG_BITS:     r_cfg.mag_bits     <= i_cfg_data[3:0];
                fpr_pkg::REG_PREC_BITS:    r_cfg.prec_bits    <= i_cfg_data[5:0];
                fpr_pkg::REG_PRUNE_ENABLE: r_cfg.prune_enable <= i_cfg_data[0];
                fpr_pkg::REG_PRUNE_LSB:    r_cfg.prune_lsb    <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !r_in_valid || lim_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_sample <= s_axis_tdata[SAMPLE_WIDTH-1:0];
        end
    end

    fpr_limit #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_limit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (r_in_valid),
        .o_ready  (lim_ready),
        .i_sample (r_in_sample),
        .o_valid  (lim_valid),
        .i_ready  (post_ready),
        .o_value  (lim_value)
    );

    fpr_post #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_post (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (lim_valid),
        .o_ready        (post_ready),
        .i_value        (lim_value),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_quantized    (quantized),
        .o_is_zero      (m_axis_tuser),
        .o_zero_total   (zero_total),
        .o_sample_total (sample_total)
    );

    generate
        if (PAD_W > 0) begin : g_pad
            assign m_axis_tdata = {{PAD_W{1'b0}}, sample_total, zero_total, quantized};
        end else begin : g_nopad
            assign m_axis_tdata = {sample_total, zero_total, quantized};
        end
    endgenerate

endmodule

### sim/fixed_point_requantizer_checker.sv
`timescale 1ns / 1ps
// checker for the fixed point requantizer: follows config writes, predicts each
// result from accepted samples and compares it field by field; depends on fpr_pkg
module fixed_point_requantizer_checker #(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_WIDTH = 32,
    parameter int IN_W         = 32,
    parameter int OUT_W        = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [fpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [IN_W-1:0]                i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [OUT_W-1:0]               i_out_data,
    input  logic                           i_out_user,
    output int                             o_err_count,
    output int                             o_pending
);

    localparam int                        MAX_REPORTS = 10;
    localparam logic [fpr_pkg::CNT_W-1:0] CNT_MAX     = '1;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0]   quantized;
        logic                      is_zero;
        logic [fpr_pkg::CNT_W-1:0] zero_total;
        logic [fpr_pkg::CNT_W-1:0] sample_total;
    } t_requant_result;

    fpr_pkg::t_cfg             cfg_q;
    logic [fpr_pkg::CNT_W-1:0] zeros_seen;
    logic [fpr_pkg::CNT_W-1:0] sample_count;
    t_requant_result           pending_results[$];
    int                        mismatches = 0;

    assign o_err_count = mismatches;

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // drop fraction bits below the quantum, toward zero or half away from zero
    function automatic logic signed [63:0] chop(input logic signed [63:0] v, input int sh,
                                               input bit half_up);
        logic [63:0] m;
        m = abs64(v);
        if (half_up && sh > 0) m = m + (64'd1 << (sh - 1));
        m = (m >> sh) << sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] clip_sym(input logic signed [63:0] v,
                                                   input logic signed [63:0] b);
        logic signed [63:0] r;
        r = v;
        if (r > b) r = b;
        if (r < -b) r = -b;
        return r;
    endfunction

    function automatic t_requant_result requantize(input logic [SAMPLE_WIDTH-1:0] sample);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] bound;
        logic signed [63:0] hi;
        logic signed [63:0] smax;
        logic signed [63:0] smin;
        int                 sh;
        int                 e;
        t_requant_result    res;
        x     = {{(64-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
        smax  = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
        smin  = -smax - 64'sd1;
        bound = 64'sd1 <<< (int'(cfg_q.mag_bits) + FRAC_BITS);
        sh    = FRAC_BITS - int'(cfg_q.prec_bits);
        if (sh < 0) sh = 0;
        if (sh > fpr_pkg::SH_CAP) sh = fpr_pkg::SH_CAP;
        case (cfg_q.limit_mode)
            fpr_pkg::MODE_CLAMP:      y = clip_sym(x, bound);
            fpr_pkg::MODE_TRUNC:      y = chop(x, sh, 1'b0);
            fpr_pkg::MODE_ROUND_CLMP: begin
                hi = bound - (64'sd1 <<< sh);
                y  = chop(x, sh, cfg_q.prec_bits >= 0);
                if (y > hi) y = hi;
                if (y < -bound) y = -bound;
            end
            fpr_pkg::MODE_CLMP_TRUNC: y = chop(clip_sym(x, bound), sh, 1'b0);
            default:                  y = x;
        endcase
        if (y > smax) y = smax;
        if (y < smin) y = smin;
        // deadzone
        e = int'(cfg_q.prune_lsb) + FRAC_BITS;
        if (cfg_q.prune_enable && e >= 0 && abs64(y) < (64'd1 << e)) y = '0;
        if (sample_count != CNT_MAX) sample_count = sample_count + 1'b1;
        if (y == 0 && zeros_seen != CNT_MAX) zeros_seen = zeros_seen + 1'b1;
        res.quantized    = y[SAMPLE_WIDTH-1:0];
        res.is_zero      = (y == 0);
        res.zero_total   = zeros_seen;
        res.sample_total = sample_count;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_requant_result want;
        t_requant_result got;
        if (!i_rst_n) begin
            cfg_q        = fpr_pkg::CFG_RESET;
            zeros_seen   = '0;
            sample_count = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    fpr_pkg::REG_LIMIT_MODE:   cfg_q.limit_mode   = i_cfg_data[2:0];
                    fpr_pkg::REG_MAG_BITS:     cfg_q.mag_bits     = i_cfg_data[3:0];
                    fpr_pkg::REG_PREC_BITS:    cfg_q.prec_bits    = i_cfg_data[5:0];
                    fpr_pkg::REG_PRUNE_ENABLE: cfg_q.prune_enable = i_cfg_data[0];
                    fpr_pkg::REG_PRUNE_LSB:    cfg_q.prune_lsb    = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(requantize(i_in_data[SAMPLE_WIDTH-1:0]));
            if (i_out_valid && i_out_ready) begin
                got.quantized    = i_out_data[SAMPLE_WIDTH-1:0];
                got.zero_total   = i_out_data[SAMPLE_WIDTH+fpr_pkg::CNT_W-1:SAMPLE_WIDTH];
                got.sample_total =
                    i_out_data[SAMPLE_WIDTH+2*fpr_pkg::CNT_W-1:SAMPLE_WIDTH+fpr_pkg::CNT_W];
                got.is_zero      = i_out_user;
                if (pending_results.size() == 0) begin
                    note_mismatch("unrequested result", '0, 64'(got.quantized));
                end else begin
                    want = pending_results.pop_front();
                    if (got.quantized !== want.quantized)
                        note_mismatch("quantized", 64'(want.quantized), 64'(got.quantized));
                    if (got.is_zero !== want.is_zero)
                        note_mismatch("is_zero", 64'(want.is_zero), 64'(got.is_zero));
                    if (got.zero_total !== want.zero_total)
                        note_mismatch("zero_total", 64'(want.zero_total), 64'(got.zero_total));
                    if (got.sample_total !== want.sample_total)
                        note_mismatch("sample_total", 64'(want.sample_total),
                                      64'(got.sample_total));
                end
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

### sim/fixed_point_requantizer_tb.sv
`timescale 1ns / 1ps
// top of the requantizer testbench: clock, reset, config phases, sample and
// backpressure stimulus, watchdog and verdict; depends on fpr_pkg, the block and its checker
module fixed_point_requantizer_tb;

    localparam int FRAC_BITS       = 16;
    localparam int SAMPLE_WIDTH    = 32;
    localparam int IN_W            = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_W           = ((SAMPLE_WIDTH + 96 + 7) / 8) * 8;
    localparam int IDLE_LIMIT      = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 34;

    localparam logic [fpr_pkg::CFG_IDX_W-1:0] REG_SPARE       = 3'd5;
    localparam logic [2:0]                    MODE_UNUSED_TOP = 3'd7;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [fpr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [fpr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [IN_W-1:0]                s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [OUT_W-1:0]               m_axis_tdata;
    logic                           m_axis_tuser;

    int err_count;
    int pending;
    int idle_cycles = 0;
    bit tx_busy = 1'b0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit hold_off_req = 1'b0;
    int cur_mag = 14;
    int cur_prec = 16;
    int cur_lsb = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    fixed_point_requantizer #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fixed_point_requantizer_checker #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IN_W         (IN_W),
        .OUT_W        (OUT_W)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random samples and samples aimed at the clamp bound, the quantum edges and the deadzone edge
    function automatic logic [IN_W-1:0] rand_sample();
        int               k;
        int               sh;
        int               e;
        logic [IN_W-1:0]  v;
        sh = FRAC_BITS - cur_prec;
        if (sh < 0) sh = 0;
        if (sh > 31) sh = 31;
        e = cur_lsb + FRAC_BITS;
        if (e < 0) e = 0;
        if (e > 31) e = 31;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: begin
                k = $urandom_range(0, 31);
                v = $urandom & ((32'd1 << k) - 32'd1);
            end
            2: v = (32'd1 << (cur_mag + FRAC_BITS)) + $urandom_range(0, 8) - 32'd4;
            3: v = ($urandom << sh) + ((sh > 0) ? (32'd1 << (sh - 1)) : 32'd0)
                   + $urandom_range(0, 2) - 32'd1;
            default: v = (32'd1 << e) + $urandom_range(0, 2) - 32'd1;
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic push_sample(input logic [IN_W-1:0] v);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        tx_busy = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        g = tx_quiet ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            tx_busy = 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic settle();
        if (tx_busy) begin
            s_axis_tvalid <= 1'b0;
            tx_busy = 1'b0;
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fpr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fpr_pkg::CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // unused high data bits carry junk, the block must ignore them
    task automatic apply_config(input logic [2:0] mode, input int mag, input int prec,
                                input bit en, input int lsb);
        settle();
        write_reg(fpr_pkg::REG_LIMIT_MODE, {3'($urandom), mode});
        write_reg(fpr_pkg::REG_MAG_BITS, {2'($urandom), 4'(mag)});
        write_reg(fpr_pkg::REG_PREC_BITS, 6'(prec));
        write_reg(fpr_pkg::REG_PRUNE_ENABLE, {5'($urandom), en});
        write_reg(fpr_pkg::REG_PRUNE_LSB, {1'($urandom), 5'(lsb)});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE + fpr_pkg::CFG_IDX_W'($urandom_range(0, 2)), 6'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cur_mag  = mag;
        cur_prec = prec;
        cur_lsb  = lsb;
    endtask

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("fixed_point_requantizer verification failed");
        $finish;
    end

    initial begin : receiver
        int g;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            g = rx_quiet ? 0 : gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [2:0] mode;
        int         mag;
        int         prec;
        int         lsb;
        int         r;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: plain pass of the sample extremes
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        // narrowest clamp
        apply_config(fpr_pkg::MODE_CLAMP, 0, 16, 1'b0, 0);
        push_sample(32'h0001_0001);
        push_sample(32'hFFFE_FFFF);
        push_sample(32'h0001_0000);
        // rounding at half a unit with a zero-width upper range
        apply_config(fpr_pkg::MODE_ROUND_CLMP, 0, 0, 1'b0, 0);
        push_sample(32'h0000_8000);
        push_sample(32'hFFFF_8000);
        push_sample(32'h0000_7FFF);
        push_sample(32'h0000_FFFF);
        // negative precision, upper bound below lower bound
        apply_config(fpr_pkg::MODE_ROUND_CLMP, 0, -14, 1'b0, 0);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h0001_2345);
        // quantum finer than one raw unit
        apply_config(fpr_pkg::MODE_TRUNC, 14, 31, 1'b0, 0);
        push_sample(32'h0000_0001);
        push_sample(32'hFFFF_FFFF);
        // coarsest quantum
        apply_config(fpr_pkg::MODE_TRUNC, 14, -32, 1'b0, 0);
        push_sample(32'h7FFF_FFFF);
        // bound past the sample range
        apply_config(fpr_pkg::MODE_CLMP_TRUNC, 15, 1, 1'b0, 0);
        push_sample(32'h8000_0000);
        push_sample(32'h7FFF_FFFF);
        // unused mode with the widest deadzone
        apply_config(MODE_UNUSED_TOP, 14, 16, 1'b1, 15);
        push_sample(32'h8000_0000);
        push_sample(32'h7FFF_FFFF);
        // deadzone of one unit
        apply_config(fpr_pkg::MODE_CLAMP, 14, 16, 1'b1, 0);
        push_sample(32'h0000_FFFF);
        push_sample(32'h0001_0000);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            r = $urandom_range(0, 9);
            if (r < 8) mode = fpr_pkg::MODE_CLAMP + 3'(r % 4);
            else if (r == 8) mode = fpr_pkg::MODE_PASS;
            else mode = fpr_pkg::MODE_CLMP_TRUNC + 3'($urandom_range(1, 3));
            case ($urandom_range(0, 5))
                0: mag = 0;
                1: mag = 14;
                2: mag = 15;
                default: mag = $urandom_range(0, 15);
            endcase
            case ($urandom_range(0, 7))
                0: prec = -32;
                1: prec = 31;
                2: prec = 16;
                3: prec = -14;
                default: prec = int'($urandom_range(0, 40)) - 20;
            endcase
            case ($urandom_range(0, 4))
                0: lsb = -16;
                1: lsb = 15;
                default: lsb = int'($urandom_range(0, 31)) - 16;
            endcase
            apply_config(mode, mag, prec, 1'($urandom), lsb);
            tx_quiet = (ph % 5 == 1);
            rx_quiet = (ph % 5 == 2);
            if (ph == 3 || $urandom_range(0, 15) == 0) hold_off_req = 1'b1;
            repeat ($urandom_range(30, 70)) push_sample(rand_sample());
        end

        settle();
        if (err_count == 0 && pending == 0) begin
            $display("fixed_point_requantizer verification clean");
        end else begin
            $display("fixed_point_requantizer verification failed");
        end
        $finish;
    end

endmodule
